FILE: src/seconds_to_local_date_unit_macros.svh
// Assertion helpers for the date conversion unit.
`ifndef SECONDS_TO_LOCAL_DATE_UNIT_MACROS_SVH
`define SECONDS_TO_LOCAL_DATE_UNIT_MACROS_SVH

// Condition holds in the same cycle.
`define STLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds in the following cycle.
`define STLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/stld_pkg.sv
package stld_pkg;

   // Shared divider: first shifted divisor and bit index for each pass
   localparam logic [31:0] DAY_DIV_INIT   = 32'd2831155200; // 86400 << 15
   localparam logic [3:0]  DAY_DIV_TOP    = 4'd15;
   localparam logic [31:0] HOUR_DIV_INIT  = 32'd57600;      // 3600 << 4
   localparam logic [3:0]  HOUR_DIV_TOP   = 4'd4;
   localparam logic [31:0] MIN_DIV_INIT   = 32'd1920;       // 60 << 5
   localparam logic [3:0]  MIN_DIV_TOP    = 4'd5;
   localparam logic [31:0] WDAY_DIV_INIT  = 32'd28672;      // 7 << 12
   localparam logic [3:0]  WDAY_DIV_TOP   = 4'd12;

   localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
   localparam logic [31:0] EPOCH_WEEKDAY  = 32'd4;          // 1970-01-01 was a Thursday

   // Calendar
   localparam logic [11:0] YEAR_EPOCH     = 12'd1970;
   localparam logic [11:0] YEAR_NO_LEAP   = 12'd2100;       // only non-leap century in range
   localparam logic [8:0]  DAYS_COMMON    = 9'd365;
   localparam logic [8:0]  DAYS_LEAP      = 9'd366;
   localparam logic [3:0]  MONTH_LAST_IDX = 4'd11;          // zero-based December

   // Summer-time rule
   localparam logic [3:0]  MONTH_MAR      = 4'd3;
   localparam logic [3:0]  MONTH_OCT      = 4'd10;
   localparam logic [4:0]  LAST_WEEK_DAY  = 5'd25;
   localparam logic [4:0]  DST_HOUR       = 5'd2;

   localparam logic signed [16:0] OFFSET_RESET = 17'sd3600;

   // Length of a month, zero-based month index
   function automatic logic [4:0] month_days(input logic [3:0] mon_idx, input logic leap);
      logic [4:0] len;
      case (mon_idx) inside
         4'd1:                   len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: src/seconds_to_local_date_unit.sv
// Converts a 32-bit count of seconds since 1970-01-01 UTC into second, minute, hour,
// weekday, day, month and year, either in UTC (req_mode 0) or in local time with the
// EU summer-time rule (req_mode 1, zone offset from csr_wdata). A transaction is taken
// when start is high and busy is low; busy then stays high until the result has been
// shown. The result appears for exactly one cycle with rsp_strobe and cannot be held
// off, so the receiver must capture it on that cycle. All work runs through one
// 33-bit subtract/compare unit: one pass is 40 restoring-division steps (days, hour,
// minute, weekday), one step per elapsed year (up to 137) and one per month (up to
// 12), plus a rule check. Transactions take longest for late dates in summer time,
// where the year loop runs twice.
`include "seconds_to_local_date_unit_macros.svh"

module seconds_to_local_date_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_epoch_seconds,
   input  logic               req_mode,
   input  logic               csr_we,
   input  logic signed [16:0] csr_wdata,
   output logic               rsp_strobe,
   output logic [5:0]         rsp_second,
   output logic [5:0]         rsp_minute,
   output logic [4:0]         rsp_hour,
   output logic [2:0]         rsp_day_of_week,
   output logic [4:0]         rsp_day_of_month,
   output logic [3:0]         rsp_month,
   output logic [11:0]        rsp_year,
   output logic               rsp_summer_time
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DAYS, ST_HOUR, ST_MIN, ST_WDAY, ST_YEAR, ST_MONTH, ST_CHECK, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic signed [16:0] offset_ff, offset_in;
   logic [31:0]        local_ff, local_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        div_ff, div_in;
   logic [15:0]        quo_ff, quo_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [15:0]        days_ff, days_in;
   logic [4:0]         hour_ff, hour_in;
   logic [5:0]         min_ff, min_in;
   logic [5:0]         sec_ff, sec_in;
   logic [2:0]         wday_ff, wday_in;
   logic [11:0]        year_ff, year_in;
   logic [3:0]         mon_ff, mon_in;
   logic               mode_ff, mode_in;
   logic               flag_ff, flag_in;

   // Shared subtract/compare unit
   logic [31:0] op_a, op_b;
   logic [32:0] diff;
   logic        ge;
   logic [31:0] rem_nx;
   logic [15:0] quo_nx;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  month_len;

   // Summer-time decision
   logic [4:0]  mday;
   logic [3:0]  mon_num;
   logic        last_week, sunday, past_last_sunday, summer;
   logic [31:0] start_local;

   // Leap years in 1970..2106: divisible by 4, except 2100 (2000 is leap)
   assign leap      = (year_ff[1:0] == 2'b00) && (year_ff != stld_pkg::YEAR_NO_LEAP);
   assign year_len  = leap ? stld_pkg::DAYS_LEAP : stld_pkg::DAYS_COMMON;
   assign month_len = stld_pkg::month_days(mon_ff, leap);

   // Operand select and subtract
   always_comb begin
      op_a = rem_ff;
      op_b = div_ff;
      case (state_ff)
         ST_YEAR: begin
            op_a = {16'b0, days_ff};
            op_b = {23'b0, year_len};
         end
         ST_MONTH: begin
            op_a = {16'b0, days_ff};
            op_b = {27'b0, month_len};
         end
         default: ;
      endcase
      diff   = {1'b0, op_a} - {1'b0, op_b};
      ge     = ~diff[32];
      rem_nx = ge ? diff[31:0] : rem_ff;
      quo_nx = {quo_ff[14:0], ge};
   end

   // EU rule on the standard-time breakdown
   assign mday             = days_ff[4:0] + 5'd1;
   assign mon_num          = mon_ff + 4'd1;
   assign last_week        = mday >= stld_pkg::LAST_WEEK_DAY;
   assign sunday           = wday_ff == 3'd0;
   assign past_last_sunday = ({1'b0, mday} + 6'd7) > (6'd31 + {3'b0, wday_ff});

   always_comb begin
      summer = 1'b0;
      if (mon_num > stld_pkg::MONTH_MAR && mon_num < stld_pkg::MONTH_OCT) begin
         summer = 1'b1;
      end else if (mon_num == stld_pkg::MONTH_MAR) begin
         if (!last_week)  summer = 1'b0;
         else if (sunday) summer = hour_ff >= stld_pkg::DST_HOUR;
         else             summer = past_last_sunday;
      end else if (mon_num == stld_pkg::MONTH_OCT) begin
         if (!last_week)  summer = 1'b1;
         else if (sunday) summer = hour_ff < stld_pkg::DST_HOUR;
         else             summer = ~past_last_sunday;
      end
   end

   assign start_local = req_mode ?
                        req_epoch_seconds + {{15{offset_ff[16]}}, offset_ff} :
                        req_epoch_seconds;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      offset_in = csr_we ? csr_wdata : offset_ff;
      local_in  = local_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      min_in    = min_ff;
      sec_in    = sec_ff;
      wday_in   = wday_ff;
      year_in   = year_ff;
      mon_in    = mon_ff;
      mode_in   = mode_ff;
      flag_in   = flag_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (start) begin
               local_in = start_local;
               mode_in  = req_mode;
               flag_in  = 1'b0;
               rem_in   = start_local;
               div_in   = stld_pkg::DAY_DIV_INIT;
               cnt_in   = stld_pkg::DAY_DIV_TOP;
               quo_in   = '0;
               state_in = ST_DAYS;
            end
         end
         ST_DAYS, ST_HOUR, ST_MIN, ST_WDAY: begin
            // one restoring-division step
            rem_in = rem_nx;
            quo_in = quo_nx;
            div_in = div_ff >> 1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               quo_in = '0;
               case (state_ff)
                  ST_DAYS: begin
                     days_in  = quo_nx;
                     div_in   = stld_pkg::HOUR_DIV_INIT;
                     cnt_in   = stld_pkg::HOUR_DIV_TOP;
                     state_in = ST_HOUR;
                  end
                  ST_HOUR: begin
                     hour_in  = quo_nx[4:0];
                     div_in   = stld_pkg::MIN_DIV_INIT;
                     cnt_in   = stld_pkg::MIN_DIV_TOP;
                     state_in = ST_MIN;
                  end
                  ST_MIN: begin
                     min_in   = quo_nx[5:0];
                     sec_in   = rem_nx[5:0];
                     rem_in   = {16'b0, days_ff} + stld_pkg::EPOCH_WEEKDAY;
                     div_in   = stld_pkg::WDAY_DIV_INIT;
                     cnt_in   = stld_pkg::WDAY_DIV_TOP;
                     state_in = ST_WDAY;
                  end
                  default: begin
                     wday_in  = rem_nx[2:0];
                     year_in  = stld_pkg::YEAR_EPOCH;
                     state_in = ST_YEAR;
                  end
               endcase
            end
         end
         ST_YEAR: begin
            if (ge) begin
               days_in = diff[15:0];
               year_in = year_ff + 12'd1;
            end else begin
               mon_in   = '0;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (ge && mon_ff != stld_pkg::MONTH_LAST_IDX) begin
               days_in = diff[15:0];
               mon_in  = mon_ff + 4'd1;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // summer time: add the hour and redo the breakdown once
            if (mode_ff && !flag_ff && summer) begin
               flag_in  = 1'b1;
               local_in = local_ff + stld_pkg::SECS_PER_HOUR;
               rem_in   = local_ff + stld_pkg::SECS_PER_HOUR;
               div_in   = stld_pkg::DAY_DIV_INIT;
               cnt_in   = stld_pkg::DAY_DIV_TOP;
               state_in = ST_DAYS;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         offset_ff <= stld_pkg::OFFSET_RESET;
      end else begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
      end
      local_ff <= local_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      days_ff  <= days_in;
      hour_ff  <= hour_in;
      min_ff   <= min_in;
      sec_ff   <= sec_in;
      wday_ff  <= wday_in;
      year_ff  <= year_in;
      mon_ff   <= mon_in;
      mode_ff  <= mode_in;
      flag_ff  <= flag_in;
   end

   // Result transaction
   assign busy             = state_ff != ST_IDLE;
   assign rsp_strobe       = state_ff == ST_DONE;
   assign rsp_second       = sec_ff;
   assign rsp_minute       = min_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_day_of_week  = wday_ff;
   assign rsp_day_of_month = mday;
   assign rsp_month        = mon_num;
   assign rsp_year         = year_ff;
   assign rsp_summer_time  = flag_ff;

   // Checks
   `STLD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")
   `STLD_ASSERT_NEXT(a_done_idle, clock, reset, rsp_strobe, !busy && !rsp_strobe, "result not followed by idle")
   `STLD_ASSERT_NOW(a_utc_no_dst, clock, reset, rsp_strobe && !mode_ff, !rsp_summer_time, "summer time set in UTC mode")
   `STLD_ASSERT_NOW(a_date_range, clock, reset, rsp_strobe, rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month != 5'd0 && rsp_day_of_week <= 3'd6, "result date out of range")

endmodule
